### src/binary_image_2x2_square_cover_check_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 square cover check core
// Concurrent checks on clock, held off while reset is high; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_2X2_SQUARE_COVER_CHECK_CORE_ASSERT_SVH
`define BINARY_IMAGE_2X2_SQUARE_COVER_CHECK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define BSC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// post must hold in the cycle after pre
`define BSC_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define BSC_ASSERT(name, prop, msg)
`define BSC_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

### src/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants and types of the 2x2 square cover check core.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 64;

   localparam int DIM_W      = 7;
   localparam int COORD_W    = 6;
   localparam int COUNT_W    = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
   localparam logic [DIM_W-1:0]   DIM_RESET = 7'd64;
   localparam logic [DIM_W-1:0]   DIM_MIN   = 7'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_COLS = 1'b1;

   // result kinds
   localparam logic KIND_SQUARE  = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic pix;
      logic win;
   } line_entry_type;

   typedef struct packed {
      logic               kind;
      logic [COORD_W-1:0] square_row;
      logic [COORD_W-1:0] square_col;
      logic               cover_ok;
      logic [COUNT_W-1:0] square_count;
      logic               last;
   } rsp_item_type;

   // second is only ever set together with first
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

`default_nettype wire

### src/bsc_line_buf.sv
// ----------------------------------------------------------------------------
// bsc_line_buf
// One row of pixel and window flags, one write and one registered read per
// cycle, with write-to-read forwarding and per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_line_buf #(
   parameter int DEPTH = bsc_pkg::DEF_MAX_COLS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        wr_en,
   input  wire  [$clog2(DEPTH)-1:0]   wr_addr,
   input  bsc_pkg::line_entry_type    wr_data,
   input  wire                        rd_en,
   input  wire  [$clog2(DEPTH)-1:0]   rd_addr,
   output bsc_pkg::line_entry_type    rd_data
);

   bsc_pkg::line_entry_type line_mem_ff [DEPTH];
   logic [DEPTH-1:0]        vld_ff;

   bsc_pkg::line_entry_type rd_mem_ff;
   bsc_pkg::line_entry_type rd_wdata_ff;
   logic                    rd_fwd_ff;
   logic                    rd_vld_ff;
   logic                    rd_fwd_in;
   logic                    rd_vld_in;

   assign rd_fwd_in = wr_en && (wr_addr == rd_addr);
   assign rd_vld_in = rd_fwd_in || vld_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mem_ff <= line_mem_ff[rd_addr];
      end
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_fwd_ff   <= rd_fwd_in;
         rd_vld_ff   <= rd_vld_in;
         rd_wdata_ff <= wr_data;
      end
   end

   always_comb begin
      if (!rd_vld_ff) begin
         rd_data = '0;
      end else if (rd_fwd_ff) begin
         rd_data = rd_wdata_ff;
      end else begin
         rd_data = rd_mem_ff;
      end
   end

endmodule

`default_nettype wire

### src/bsc_rsp_fifo.sv
// ----------------------------------------------------------------------------
// bsc_rsp_fifo
// Four-entry result queue, up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_image_2x2_square_cover_check_core_assert.svh"

module bsc_rsp_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  bsc_pkg::push_type       push,
   input  bsc_pkg::rsp_item_type   item_a,
   input  bsc_pkg::rsp_item_type   item_b,
   output logic                    room,
   output logic                    out_valid,
   input  wire                     out_stall,
   output bsc_pkg::rsp_item_type   out_item
);

   bsc_pkg::rsp_item_type              entry_ff [bsc_pkg::RSP_DEPTH];
   logic [bsc_pkg::RSP_PTR_W-1:0]      wr_ptr_ff;
   logic [bsc_pkg::RSP_PTR_W-1:0]      rd_ptr_ff;
   logic [bsc_pkg::RSP_CNT_W-1:0]      count_ff;
   logic [bsc_pkg::RSP_PTR_W-1:0]      wr_ptr_in;
   logic [bsc_pkg::RSP_PTR_W-1:0]      rd_ptr_in;
   logic [bsc_pkg::RSP_CNT_W-1:0]      count_in;
   logic [bsc_pkg::RSP_CNT_W-1:0]      push_n;
   logic                               pop;

   assign push_n    = bsc_pkg::RSP_CNT_W'(push.first) + bsc_pkg::RSP_CNT_W'(push.second);
   assign pop       = out_valid && !out_stall;
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   // room flags that space for a pair of pushes is left
   assign room      = (count_ff <= bsc_pkg::RSP_CNT_W'(bsc_pkg::RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + bsc_pkg::RSP_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + bsc_pkg::RSP_PTR_W'(pop);
   assign count_in  = count_ff + push_n - bsc_pkg::RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= item_a;
      end
      if (push.second) begin
         entry_ff[wr_ptr_ff + bsc_pkg::RSP_PTR_W'(1)] <= item_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BSC_ASSERT(a_fifo_bounded, (count_ff <= bsc_pkg::RSP_CNT_W'(bsc_pkg::RSP_DEPTH)), "result queue overflow")
   `BSC_ASSERT(a_fifo_pair_order, (push.second |-> push.first), "second push without first")

endmodule

`default_nettype wire

### src/binary_image_2x2_square_cover_check_core.sv
// ----------------------------------------------------------------------------
// binary_image_2x2_square_cover_check_core
// Results enter a four-entry queue as their pixel is taken and are offered
// on rsp_valid from its head. Throughput: one pixel per cycle unless req_stall
// is high (room for a pair lacking); an image's last pixel may give two results.
// Reset: synchronous, active high; counters, flags and queue are cleared and
// both size registers return to 64. Line buffers are not swept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_image_2x2_square_cover_check_core_assert.svh"

module binary_image_2x2_square_cover_check_core #(
   parameter int MAX_COLS = bsc_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = bsc_pkg::DEF_MAX_ROWS
) (
   input  wire                                clock,
   input  wire                                reset,
   // pixel requests
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_pixel,
   // results
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_kind,
   output logic [bsc_pkg::COORD_W-1:0]        rsp_square_row,
   output logic [bsc_pkg::COORD_W-1:0]        rsp_square_col,
   output logic                               rsp_cover_ok,
   output logic [bsc_pkg::COUNT_W-1:0]        rsp_square_count,
   output logic                               rsp_last,
   // size registers
   input  wire                                csr_wr_en,
   input  wire  [bsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [bsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   // compare widths hold both the 7-bit register and the maximum
   localparam int CCMP_W = ((COL_W > bsc_pkg::DIM_W) ? COL_W : bsc_pkg::DIM_W) + 1;
   localparam int RCMP_W = ((ROW_W > bsc_pkg::DIM_W) ? ROW_W : bsc_pkg::DIM_W) + 1;

   // ---------------------------------------------------------------- registers
   logic [bsc_pkg::DIM_W-1:0]   rows_ff;
   logic [bsc_pkg::DIM_W-1:0]   cols_ff;
   logic [ROW_W-1:0]            row_ff;
   logic [COL_W-1:0]            col_ff;
   logic                        prev_pix_ff;
   logic                        prev_win_ff;
   logic                        mism_ff;
   logic [bsc_pkg::COUNT_W-1:0] found_ff;
   bsc_pkg::line_entry_type     up_left_ff;   // previous row, column c-1
   // deferred write of the last column's entry, flushed the next cycle
   logic                        pend_ff;
   logic [COL_W-1:0]            pend_addr_ff;
   bsc_pkg::line_entry_type     pend_data_ff;

   logic [ROW_W-1:0]            row_in;
   logic [COL_W-1:0]            col_in;
   logic                        mism_in;
   logic [bsc_pkg::COUNT_W-1:0] found_in;

   // ---------------------------------------------------------------- datapath
   logic                        req_accept;
   logic [CCMP_W-1:0]           cols_raw;
   logic [CCMP_W-1:0]           cols_use;
   logic [RCMP_W-1:0]           rows_raw;
   logic [RCMP_W-1:0]           rows_use;
   logic                        end_row;
   logic                        last_row;
   logic                        verdict;
   logic                        r_nz;
   logic                        c_nz;
   logic                        win;
   logic                        chk_inner;
   logic                        chk_edge;
   logic                        chk_last_left;
   logic                        chk_last_end;
   logic                        mism_now;
   logic [bsc_pkg::COUNT_W-1:0] found_now;
   bsc_pkg::line_entry_type     up_cur;       // previous row, column c

   logic                        lb_wr_en;
   logic [COL_W-1:0]            lb_wr_addr;
   bsc_pkg::line_entry_type     lb_wr_data;
   logic [COL_W-1:0]            lb_rd_addr;

   bsc_pkg::push_type           push;
   bsc_pkg::rsp_item_type       sq_item;
   bsc_pkg::rsp_item_type       vd_item;
   bsc_pkg::rsp_item_type       item_a;
   bsc_pkg::rsp_item_type       head;
   logic                        room;

   assign req_stall  = !room;
   assign req_accept = req_valid && !req_stall;

   // sizes in use, clamped to 2..MAX
   assign cols_raw = CCMP_W'(cols_ff);
   assign rows_raw = RCMP_W'(rows_ff);

   always_comb begin
      if (cols_raw < CCMP_W'(bsc_pkg::DIM_MIN)) begin
         cols_use = CCMP_W'(bsc_pkg::DIM_MIN);
      end else if (cols_raw > CCMP_W'(MAX_COLS)) begin
         cols_use = CCMP_W'(MAX_COLS);
      end else begin
         cols_use = cols_raw;
      end
   end

   always_comb begin
      if (rows_raw < RCMP_W'(bsc_pkg::DIM_MIN)) begin
         rows_use = RCMP_W'(bsc_pkg::DIM_MIN);
      end else if (rows_raw > RCMP_W'(MAX_ROWS)) begin
         rows_use = RCMP_W'(MAX_ROWS);
      end else begin
         rows_use = rows_raw;
      end
   end

   // a counter at or past the end (size shrunk mid-image) counts as the end
   assign end_row  = (CCMP_W'(col_ff) + CCMP_W'(1)) >= cols_use;
   assign last_row = (RCMP_W'(row_ff) + RCMP_W'(1)) >= rows_use;
   assign verdict  = end_row && last_row;
   assign r_nz     = (row_ff != '0);
   assign c_nz     = (col_ff != '0);

   // window ending at (r, c): all four pixels set
   assign win = r_nz && c_nz && req_pixel && prev_pix_ff && up_cur.pix && up_left_ff.pix;

   // pixel (r-1, c-1): all four windows over it are now known
   assign chk_inner = r_nz && c_nz &&
      (up_left_ff.pix != (up_left_ff.win | up_cur.win | prev_win_ff | win));
   // pixel (r-1, last column)
   assign chk_edge = r_nz && end_row && (up_cur.pix != (up_cur.win | win));
   // last row: the pixel to the left, and the corner pixel itself
   assign chk_last_left = last_row && c_nz && (prev_pix_ff != (prev_win_ff | win));
   assign chk_last_end  = last_row && end_row && (req_pixel != win);

   assign mism_now  = mism_ff | chk_inner | chk_edge | chk_last_left | chk_last_end;
   assign found_now = (win && (found_ff != bsc_pkg::COUNT_MAX)) ?
                      found_ff + bsc_pkg::COUNT_W'(1) : found_ff;

   // ---------------------------------------------------------------- line buffer
   // Lagged writes: column c-1 takes the previous pixel; at the row end the
   // current column is written in the next cycle, when the port is free since
   // the next pixel is at column 0.
   always_comb begin
      if (req_accept && c_nz) begin
         lb_wr_en   = 1'b1;
         lb_wr_addr = col_ff - COL_W'(1);
         lb_wr_data = '{pix: prev_pix_ff, win: prev_win_ff};
      end else begin
         lb_wr_en   = pend_ff;
         lb_wr_addr = pend_addr_ff;
         lb_wr_data = pend_data_ff;
      end
   end

   // fetch the next column's entry ahead of its pixel
   assign lb_rd_addr = end_row ? '0 : col_ff + COL_W'(1);

   bsc_line_buf #(
      .DEPTH (MAX_COLS)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (lb_wr_en),
      .wr_addr (lb_wr_addr),
      .wr_data (lb_wr_data),
      .rd_en   (req_accept),
      .rd_addr (lb_rd_addr),
      .rd_data (up_cur)
   );

   // ---------------------------------------------------------------- state update
   assign col_in   = end_row ? '0 : col_ff + COL_W'(1);
   assign row_in   = end_row ? (last_row ? '0 : row_ff + ROW_W'(1)) : row_ff;
   assign mism_in  = verdict ? 1'b0 : mism_now;
   assign found_in = verdict ? '0 : found_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= bsc_pkg::DIM_RESET;
         cols_ff <= bsc_pkg::DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            bsc_pkg::CSR_IDX_ROWS: begin
               rows_ff <= csr_wdata;
            end
            bsc_pkg::CSR_IDX_COLS: begin
               cols_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         prev_pix_ff <= 1'b0;
         prev_win_ff <= 1'b0;
         mism_ff     <= 1'b0;
         found_ff    <= '0;
         pend_ff     <= 1'b0;
      end else begin
         pend_ff <= req_accept && end_row;
         if (req_accept) begin
            row_ff      <= row_in;
            col_ff      <= col_in;
            prev_pix_ff <= req_pixel;
            prev_win_ff <= win;
            mism_ff     <= mism_in;
            found_ff    <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         up_left_ff   <= up_cur;
         pend_addr_ff <= col_ff;
         pend_data_ff <= '{pix: req_pixel, win: win};
      end
   end

   // ---------------------------------------------------------------- results
   // a square found at the last pixel goes out ahead of the verdict
   assign sq_item = '{kind:         bsc_pkg::KIND_SQUARE,
                      square_row:   bsc_pkg::COORD_W'(row_ff),
                      square_col:   bsc_pkg::COORD_W'(col_ff),
                      cover_ok:     1'b0,
                      square_count: '0,
                      last:         1'b0};

   assign vd_item = '{kind:         bsc_pkg::KIND_VERDICT,
                      square_row:   '0,
                      square_col:   '0,
                      cover_ok:     !mism_now,
                      square_count: found_now,
                      last:         1'b1};

   assign item_a      = win ? sq_item : vd_item;
   assign push.first  = req_accept && (win || verdict);
   assign push.second = req_accept && win && verdict;

   bsc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .item_a    (item_a),
      .item_b    (vd_item),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (head)
   );

   assign rsp_kind         = head.kind;
   assign rsp_square_row   = head.square_row;
   assign rsp_square_col   = head.square_col;
   assign rsp_cover_ok     = head.cover_ok;
   assign rsp_square_count = head.square_count;
   assign rsp_last         = head.last;

   // ---------------------------------------------------------------- checks
   `BSC_ASSERT_NEXT(a_image_end_clears, (req_accept && verdict), (row_ff == '0 && col_ff == '0 && found_ff == '0 && !mism_ff), "state not cleared after image end")
   `BSC_ASSERT_NEXT(a_count_no_drop, (req_accept && !verdict), (found_ff >= $past(found_ff)), "square count dropped inside an image")
   `BSC_ASSERT_NEXT(a_pend_flushes, pend_ff, !pend_ff, "deferred line write held over")
   `BSC_ASSERT(a_col_in_range, (CCMP_W'(col_ff) < CCMP_W'(MAX_COLS)), "column counter out of range")

endmodule

`default_nettype wire
